// ===== sv/mft_pkg.sv =====
// Package for the Manchester frame transmitter: item structs, job struct, codes and limits.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package mft_pkg;

    localparam int QueueDepth = 2;

    localparam logic [2:0] CmdReset     = 3'd0;
    localparam logic [2:0] CmdConfig    = 3'd1;
    localparam logic [2:0] CmdScan      = 3'd2;
    localparam logic [2:0] CmdTrigger   = 3'd3;
    localparam logic [2:0] CmdHeartbeat = 3'd4;

    localparam logic [1:0] StatusSent     = 2'd0;
    localparam logic [1:0] StatusRejected = 2'd1;
    localparam logic [1:0] StatusReset    = 2'd2;

    localparam logic [15:0] FreqMin  = 16'd10;
    localparam logic [15:0] FreqMax  = 16'd20000;
    localparam logic [15:0] LevelMin = 16'd10;
    localparam logic [15:0] LevelMax = 16'd30;
    localparam logic [15:0] StepMin  = 16'd1;
    localparam logic [15:0] StepMax  = 16'd1000;

    localparam logic [7:0] FrameHead = 8'hAA;
    localparam logic [7:0] FrameTail = 8'h55;

    localparam int FrameBits = 64;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] frequency;
        logic [15:0] level_or_step;
        logic [15:0] end_frequency;
    } t_in_item;

    typedef struct packed {
        logic       has_bit;
        logic       data_bit;
        logic       first_half_level;
        logic       second_half_level;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    // One classified command: either a status answer or the six inner frame bytes.
    typedef struct packed {
        logic        is_frame;
        logic [1:0]  status;
        logic [47:0] body;
    } t_job;

endpackage
`default_nettype wire

// ===== sv/mft_front.sv =====
// Front end of the Manchester frame transmitter: checks each command and builds its job.
// Holds the ready flag and the sequence counter. Depends on mft_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mft_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire mft_pkg::t_in_item i_in_data,
    output logic                   o_job_valid,
    input  wire logic              i_job_ready,
    output mft_pkg::t_job          o_job
);

    logic [7:0] r_seq;
    logic [7:0] n_seq;
    logic       r_rdy_flag;
    logic       n_rdy_flag;

    logic       w_freq_ok;
    logic       w_end_ok;
    logic       w_level_ok;
    logic       w_step_ok;
    logic       w_send;
    logic       w_accept;
    logic [7:0] w_cmd;
    logic [7:0] w_freq_hi;
    logic [7:0] w_freq_lo;
    logic [7:0] w_payload;
    logic [7:0] w_sum;

    assign w_freq_ok  = (i_in_data.frequency >= mft_pkg::FreqMin)
                     && (i_in_data.frequency <= mft_pkg::FreqMax);
    assign w_end_ok   = (i_in_data.end_frequency >= mft_pkg::FreqMin)
                     && (i_in_data.end_frequency <= mft_pkg::FreqMax);
    assign w_level_ok = (i_in_data.level_or_step >= mft_pkg::LevelMin)
                     && (i_in_data.level_or_step <= mft_pkg::LevelMax);
    assign w_step_ok  = (i_in_data.level_or_step >= mft_pkg::StepMin)
                     && (i_in_data.level_or_step <= mft_pkg::StepMax);

    assign o_in_ready  = i_job_ready;
    assign o_job_valid = i_in_valid;
    assign w_accept    = i_in_valid && i_job_ready;
    assign w_cmd       = {5'd0, i_in_data.command};

    always_comb begin
        w_send    = 1'b0;
        w_freq_hi = 8'd0;
        w_freq_lo = 8'd0;
        w_payload = 8'd0;
        unique case (i_in_data.command)
            mft_pkg::CmdConfig: begin
                w_send    = r_rdy_flag && w_freq_ok && w_level_ok;
                w_freq_hi = i_in_data.frequency[15:8];
                w_freq_lo = i_in_data.frequency[7:0];
                w_payload = i_in_data.level_or_step[7:0];
            end
            mft_pkg::CmdScan: begin
                w_send    = w_freq_ok && w_end_ok && w_step_ok;
                w_freq_hi = i_in_data.frequency[15:8];
                w_freq_lo = i_in_data.frequency[7:0];
                w_payload = i_in_data.level_or_step[7:0];
            end
            mft_pkg::CmdTrigger, mft_pkg::CmdHeartbeat: begin
                w_send = r_rdy_flag;
            end
            default: begin
                w_send = 1'b0;
            end
        endcase
    end

    assign w_sum = w_cmd + w_freq_hi + w_freq_lo + w_payload + r_seq;

    always_comb begin
        o_job.is_frame = w_send;
        o_job.body     = {w_cmd, w_freq_hi, w_freq_lo, w_payload, r_seq, w_sum};
        if (i_in_data.command == mft_pkg::CmdReset) begin
            o_job.status = mft_pkg::StatusReset;
        end else if (w_send) begin
            o_job.status = mft_pkg::StatusSent;
        end else begin
            o_job.status = mft_pkg::StatusRejected;
        end
    end

    always_comb begin
        n_seq      = r_seq;
        n_rdy_flag = r_rdy_flag;
        if (w_accept) begin
            if (i_in_data.command == mft_pkg::CmdReset) begin
                n_seq      = 8'd0;
                n_rdy_flag = 1'b1;
            end else if (w_send) begin
                n_seq = r_seq + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= 8'd0;
            r_rdy_flag <= 1'b0;
        end else begin
            r_seq      <= n_seq;
            r_rdy_flag <= n_rdy_flag;
        end
    end

endmodule
`default_nettype wire

// ===== sv/mft_queue.sv =====
// Short job queue between the front end and the serializer of the frame transmitter.
// Register-based ring buffer; depends on mft_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none
module mft_queue #(
    parameter int QUEUE_DEPTH = mft_pkg::QueueDepth
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire mft_pkg::t_job i_push_data,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output mft_pkg::t_job      o_pop_data
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    mft_pkg::t_job   r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != CntW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    function automatic logic [PtrW-1:0] f_next(input logic [PtrW-1:0] ptr);
        if (ptr == PtrW'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + PtrW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/mft_back.sv =====
// Serializer of the frame transmitter: plays a job out as results, one per cycle while
// the output is not stalled, through an output register. Depends on mft_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mft_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    output logic               o_job_ready,
    input  wire mft_pkg::t_job i_job,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output mft_pkg::t_out_item o_out_data
);

    localparam int CntW = $clog2(mft_pkg::FrameBits);

    logic                        r_busy;
    logic                        r_is_frame;
    logic [1:0]                  r_status;
    logic [mft_pkg::FrameBits-1:0] r_shift;
    logic [CntW-1:0]             r_cnt;
    logic                        r_out_valid;
    mft_pkg::t_out_item          r_out;

    logic                        w_adv;
    logic                        w_emit;
    logic                        w_last;
    logic                        w_done;
    logic                        w_pop;
    logic                        w_bit;
    mft_pkg::t_out_item          w_item;

    assign w_adv  = !r_out_valid || i_out_ready;
    assign w_emit = r_busy && w_adv;
    assign w_last = !r_is_frame || (r_cnt == CntW'(mft_pkg::FrameBits - 1));
    assign w_done = w_emit && w_last;
    assign w_pop  = i_job_valid && (!r_busy || w_done);
    assign w_bit  = r_shift[mft_pkg::FrameBits-1];

    assign o_job_ready = !r_busy || w_done;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        w_item.has_bit           = r_is_frame;
        w_item.data_bit          = r_is_frame && w_bit;
        w_item.first_half_level  = r_is_frame && w_bit;
        w_item.second_half_level = r_is_frame && !w_bit;
        w_item.status            = r_status;
        w_item.last              = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_is_frame <= i_job.is_frame;
            r_status   <= i_job.status;
            r_shift    <= {mft_pkg::FrameHead, i_job.body, mft_pkg::FrameTail};
        end else if (w_emit) begin
            r_shift <= {r_shift[mft_pkg::FrameBits-2:0], 1'b0};
        end
        if (w_adv) begin
            r_out <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (w_emit) begin
                r_cnt <= r_cnt + CntW'(1);
            end
            if (w_adv) begin
                r_out_valid <= w_emit;
            end
        end
    end

    // A status answer is always a single, final transaction.
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.has_bit) |-> r_out.last)
        else $error("status result without last");

    // The bit counter only runs for frames.
    a_status_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_is_frame) |-> (r_cnt == '0))
        else $error("bit counter moved for a status job");

    // Every frame starts with the header byte at the head of the shifter.
    a_frame_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_is_frame && r_cnt == '0) |-> (r_shift[63:56] == mft_pkg::FrameHead))
        else $error("frame does not start with header byte");

    // A popped job is only taken when the current one has finished.
    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_done) |-> !w_pop)
        else $error("job loaded over a running job");

endmodule
`default_nettype wire

// ===== sv/manchester_frame_transmitter_unit.sv =====
// Top level of the Manchester frame transmitter: front end, job queue and serializer.
// Depends on mft_pkg, mft_front, mft_queue and mft_back.
//
//   channel   direction  signals                                  payload
//   in        to unit    i_in_valid / o_in_ready / i_in_data      mft_pkg::t_in_item
//   out       from unit  o_out_valid / i_out_ready / o_out_data   mft_pkg::t_out_item
//
// A sent frame is 64 coded bits, one per cycle from the serializer's shifter unless the
// output stalls; a status answer is one result. The serializer is the bottleneck. With it
// idle, a first result goes through the queue, the shifter and the output register.
// Commands are checked on acceptance and wait in a QUEUE_DEPTH-entry queue, so the input
// keeps accepting while a frame plays out or the output is stalled until the queue is
// full; then o_in_ready stays low until the serializer takes the next job.
// Reset is synchronous and active low; it clears the sequence, the ready flag and all
// valid state, and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module manchester_frame_transmitter_unit #(
    parameter int QUEUE_DEPTH = mft_pkg::QueueDepth
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire mft_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output mft_pkg::t_out_item      o_out_data
);

    logic          w_fq_valid;
    logic          w_fq_ready;
    mft_pkg::t_job w_fq_job;
    logic          w_qb_valid;
    logic          w_qb_ready;
    mft_pkg::t_job w_qb_job;

    mft_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (w_fq_valid),
        .i_job_ready (w_fq_ready),
        .o_job       (w_fq_job)
    );

    mft_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_data  (w_fq_job),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_data   (w_qb_job)
    );

    mft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_qb_valid),
        .o_job_ready (w_qb_ready),
        .i_job       (w_qb_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
